FILE: hw/rtl/ppi_pkg.sv
// ppi_pkg: shared types and constants for the particle pool integrator
// no dependencies
package ppi_pkg;
   localparam int PoolSize = 64;
   localparam int SlotW = $clog2(PoolSize);
   localparam logic [15:0] StepReset = 16'd1092;
   localparam logic [31:0] OneQ16 = 32'h0001_0000;

   typedef enum logic [1:0] {
      REQ_SPAWN = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_DUMP  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPAWN_RSP, ST_TICK_RD, ST_TICK_V, ST_TICK_P, ST_TICK_O1,
      ST_TICK_O2, ST_TICK_WR, ST_DUMP_RD, ST_DUMP_LOOK, ST_DUMP_RSP
   } state_type;

   typedef struct packed {
      logic             load_req;
      logic             spawn_wr;
      logic             rd;
      logic             vel_stage;
      logic             pos_stage;
      logic             op1_stage;
      logic             op2_stage;
      logic             tick_wr;
      logic             rsp_load;
      logic [SlotW-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic             free_found;
      logic [SlotW-1:0] free_slot;
      logic             live_cur;
      logic             any_live_after;
      logic [SlotW-1:0] sel_cur;
   } status_type;

   // add a signed rate*unsigned step product, floored shift by 16, saturate add
   function automatic logic signed [31:0] sat_add(logic signed [31:0] base,
                                                  logic signed [47:0] prod);
      logic signed [32:0] sh;
      logic signed [33:0] sum;
      begin
         sh  = 33'($signed(prod[47:16]));
         sum = 34'(base) + 34'(sh);
         if (sum > 34'sh0_7FFF_FFFF) sat_add = 32'sh7FFF_FFFF;
         else if (sum < -34'sh0_8000_0000) sat_add = 32'sh8000_0000;
         else sat_add = sum[31:0];
      end
   endfunction
endpackage

FILE: hw/rtl/particle_pool_integrator.sv
// particle_pool_integrator: top level of the particle pool integrator
// depends on ppi_pkg, ppi_ctrl and ppi_datapath
//
//   channel   direction  ports
//   req       in         req_valid/req_ready, req_type and spawn fields
//   rsp       out        rsp_valid/rsp_ready, slot .. is_last
//   csr       in         csr_write, csr_time_step
//
// spawn: accepted in idle, then the response state
// tick: a dead slot takes only the read state; a live slot goes through read, velocity,
//   position, two opacity multiplies and writeback
// dump: read, look and response states per live slot, plus response stalls
// reset clears the live flags at once; no clearing pass
// rsp stalls hold the controller in its response state
module particle_pool_integrator (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [15:0]        csr_time_step,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [3:0]         particle_kind,
   input  logic [23:0]        lifetime,
   input  logic signed [31:0] pos_x, pos_y, pos_z,
   input  logic signed [31:0] vel_x, vel_y, vel_z,
   input  logic signed [31:0] accel_x, accel_y, accel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         slot,
   output logic               pool_full,
   output logic               has_particle,
   output logic [3:0]         kind_out,
   output logic signed [31:0] out_x, out_y, out_z,
   output logic [31:0]        opacity,
   output logic               is_last
);
   import ppi_pkg::*;

   // time step register
   logic [15:0] step_ff;
   always_ff @(posedge clock) begin
      if (reset) step_ff <= StepReset;
      else if (csr_write) step_ff <= csr_time_step;
   end

   cmd_type cmd;
   status_type sts;
   logic rsp_is_dump, rsp_found;

   ppi_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .rsp_valid, .rsp_ready, .sts, .cmd, .rsp_is_dump, .rsp_found
   );

   ppi_datapath u_dp (
      .clock, .reset, .csr_time_step(step_ff), .cmd, .rsp_is_dump, .rsp_found,
      .particle_kind, .lifetime, .pos_x, .pos_y, .pos_z,
      .vel_x, .vel_y, .vel_z, .accel_x, .accel_y, .accel_z,
      .sts, .slot, .pool_full, .has_particle, .kind_out,
      .out_x, .out_y, .out_z, .opacity, .is_last
   );

   // a response never shows while a new item is taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("rsp and req overlap");
   // a full pool never reports a slot
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pool_full |-> slot == 6'd0 && is_last) else $error("full slot");
   // a dumped particle never flags full
   a_dump_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_particle |-> !pool_full) else $error("dump full");
endmodule

FILE: hw/rtl/ppi_ctrl.sv
// ppi_ctrl: sequencer for spawn, tick and dump items
// depends on ppi_pkg
module ppi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ppi_pkg::status_type   sts,
   output ppi_pkg::cmd_type      cmd,
   output logic                  rsp_is_dump,
   output logic                  rsp_found
);
   import ppi_pkg::*;

   state_type state_ff, state_in;
   logic [SlotW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic last_idx;

   assign last_idx = (idx_ff == SlotW'(PoolSize - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            found_in = 1'b0;
            if (req_valid) begin
               unique case (req_code_type'(req_type))
                  REQ_SPAWN: state_in = ST_SPAWN_RSP;
                  REQ_TICK:  state_in = ST_TICK_RD;
                  REQ_DUMP:  state_in = ST_DUMP_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPAWN_RSP: if (rsp_ready) state_in = ST_IDLE;
         ST_TICK_RD: state_in = sts.live_cur ? ST_TICK_V :
                                (last_idx ? ST_IDLE : ST_TICK_RD);
         ST_TICK_V:  state_in = ST_TICK_P;
         ST_TICK_P:  state_in = ST_TICK_O1;
         ST_TICK_O1: state_in = ST_TICK_O2;
         ST_TICK_O2: state_in = ST_TICK_WR;
         ST_TICK_WR: state_in = last_idx ? ST_IDLE : ST_TICK_RD;
         ST_DUMP_RD: state_in = ST_DUMP_LOOK;
         ST_DUMP_LOOK: state_in = ST_DUMP_RSP;
         ST_DUMP_RSP: if (rsp_ready) begin
            found_in = 1'b1;
            state_in = sts.any_live_after ? ST_DUMP_RD : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // index moves on in tick after a dead slot or writeback
      if (state_ff == ST_TICK_RD && !sts.live_cur && !last_idx) idx_in = idx_ff + 1'b1;
      if (state_ff == ST_TICK_WR && !last_idx) idx_in = idx_ff + 1'b1;
      // dump resumes just past the slot it sent
      if (state_ff == ST_DUMP_RSP && rsp_ready && sts.any_live_after)
         idx_in = sts.sel_cur + 1'b1;
   end

   // dump walks only live slots: DUMP_RD jumps to next live at or after idx
   always_comb begin
      cmd = '0;
      cmd.idx = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
            cmd.spawn_wr = req_valid && (req_type == REQ_SPAWN);
         end
         ST_SPAWN_RSP: rsp_valid = 1'b1;
         ST_TICK_RD: cmd.rd = 1'b1;
         ST_TICK_V:  cmd.vel_stage = 1'b1;
         ST_TICK_P:  cmd.pos_stage = 1'b1;
         ST_TICK_O1: cmd.op1_stage = 1'b1;
         ST_TICK_O2: cmd.op2_stage = 1'b1;
         ST_TICK_WR: cmd.tick_wr = 1'b1;
         ST_DUMP_RD: cmd.rd = 1'b1;
         ST_DUMP_LOOK: cmd.rsp_load = 1'b1;
         ST_DUMP_RSP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_is_dump = (state_ff == ST_DUMP_RSP);
   assign rsp_found   = found_ff;
endmodule

FILE: hw/rtl/ppi_datapath.sv
// ppi_datapath: particle stores, live flags and the euler step unit
// depends on ppi_pkg
module ppi_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                csr_time_step,
   input  ppi_pkg::cmd_type           cmd,
   input  logic                       rsp_is_dump,
   input  logic                       rsp_found,
   input  logic [3:0]                 particle_kind,
   input  logic [23:0]                lifetime,
   input  logic signed [31:0]         pos_x, pos_y, pos_z,
   input  logic signed [31:0]         vel_x, vel_y, vel_z,
   input  logic signed [31:0]         accel_x, accel_y, accel_z,
   output ppi_pkg::status_type        sts,
   output logic [5:0]                 slot,
   output logic                       pool_full,
   output logic                       has_particle,
   output logic [3:0]                 kind_out,
   output logic signed [31:0]         out_x, out_y, out_z,
   output logic [31:0]                opacity,
   output logic                       is_last
);
   import ppi_pkg::*;

   localparam int RowW = 4 + 25 + 32 * 9 + 32;
   logic [RowW-1:0] mem [PoolSize];
   logic [RowW-1:0] row_ff;
   logic [PoolSize-1:0] live_ff;
   logic [SlotW-1:0] free_slot, sel_slot, sel_ff;
   logic free_found, sel_found;

   logic signed [31:0] v_ff [3];
   logic signed [31:0] p_ff [3];
   logic signed [24:0] life_ff;
   logic [33:0] sq_ff;
   logic [31:0] op_ff;
   logic [5:0] slot_ff;
   logic full_ff;

   // lowest free slot, and lowest live slot at or after the index
   always_comb begin
      free_found = 1'b0;
      free_slot = '0;
      sel_found = 1'b0;
      sel_slot = '0;
      for (int i = PoolSize - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_slot = SlotW'(i);
         end
         if (live_ff[i] && SlotW'(i) >= cmd.idx) begin
            sel_found = 1'b1;
            sel_slot = SlotW'(i);
         end
      end
   end

   logic [PoolSize-1:0] after_mask;
   always_comb begin
      for (int i = 0; i < PoolSize; i++) after_mask[i] = (SlotW'(i) > sel_ff);
   end

   assign sts.free_found = free_found;
   assign sts.free_slot = free_slot;
   assign sts.live_cur = live_ff[cmd.idx];
   assign sts.any_live_after = |(live_ff & after_mask);
   assign sts.sel_cur = sel_ff;

   logic [SlotW-1:0] rd_addr;
   assign rd_addr = cmd.rsp_load ? sel_ff : (sel_found ? sel_slot : cmd.idx);

   // row fields
   logic [3:0] r_kind;
   logic signed [24:0] r_life;
   logic signed [31:0] r_p [3];
   logic signed [31:0] r_v [3];
   logic signed [31:0] r_a [3];
   logic [31:0] r_op;
   always_comb begin
      {r_kind, r_life, r_p[0], r_p[1], r_p[2], r_v[0], r_v[1], r_v[2],
       r_a[0], r_a[1], r_a[2], r_op} = row_ff;
   end

   logic signed [16:0] dt_s;
   assign dt_s = {1'b0, csr_time_step};
   logic [24:0] life_abs;
   assign life_abs = life_ff[24] ? 25'(-life_ff) : 25'(life_ff);
   logic [49:0] sq_full;
   assign sq_full = 50'(life_abs) * 50'(life_abs);
   logic [33:0] s_val;
   assign s_val = sq_full[49:16];
   logic [67:0] q_full;
   assign q_full = 68'(sq_ff) * 68'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         sel_ff <= '0;
      end else begin
         if (cmd.spawn_wr && free_found) live_ff[free_slot] <= 1'b1;
         if (cmd.tick_wr && (life_ff[24] || life_ff == 25'sd0)) live_ff[cmd.idx] <= 1'b0;
         if (cmd.rd) sel_ff <= rd_addr;
      end
      if (cmd.rd) row_ff <= mem[rd_addr];
      if (cmd.spawn_wr && free_found)
         mem[free_slot] <= {particle_kind, 1'b0, lifetime, pos_x, pos_y, pos_z,
                            vel_x, vel_y, vel_z, accel_x, accel_y, accel_z, OneQ16};
      if (cmd.tick_wr)
         mem[cmd.idx] <= {r_kind, life_ff, p_ff[0], p_ff[1], p_ff[2],
                          v_ff[0], v_ff[1], v_ff[2], r_a[0], r_a[1], r_a[2], op_ff};
      if (cmd.vel_stage) begin
         for (int k = 0; k < 3; k++)
            v_ff[k] <= sat_add(r_v[k], 48'(r_a[k]) * 48'(dt_s));
         life_ff <= r_life - 25'(csr_time_step);
      end
      if (cmd.pos_stage)
         for (int k = 0; k < 3; k++)
            p_ff[k] <= sat_add(r_p[k], 48'(v_ff[k]) * 48'(dt_s));
      if (cmd.op1_stage) sq_ff <= s_val;
      if (cmd.op2_stage)
         op_ff <= (|q_full[67:48]) ? 32'hFFFF_FFFF : q_full[47:16];
      if (cmd.load_req) begin
         slot_ff <= 6'(free_slot);
         full_ff <= !free_found;
      end
   end

   // dump fields come from the row, spawn fields from the captured slot
   logic dump_hit;
   assign dump_hit = rsp_is_dump && live_ff[sel_ff] && sel_ff >= cmd.idx;
   assign slot = rsp_is_dump ? (dump_hit ? 6'(sel_ff) : 6'd0) : (full_ff ? 6'd0 : slot_ff);
   assign pool_full = !rsp_is_dump && full_ff;
   assign has_particle = dump_hit;
   assign kind_out = dump_hit ? r_kind : 4'd0;
   assign out_x = dump_hit ? r_p[0] : 32'sd0;
   assign out_y = dump_hit ? r_p[1] : 32'sd0;
   assign out_z = dump_hit ? r_p[2] : 32'sd0;
   assign opacity = dump_hit ? r_op : 32'd0;
   assign is_last = rsp_is_dump ? (!sts.any_live_after || (!dump_hit && !rsp_found)) : 1'b1;
endmodule

FILE: dv/particle_pool_integrator_tb.sv
// particle_pool_integrator_tb: self-checking testbench for the particle pool integrator
// depends on ppi_pkg and the particle_pool_integrator rtl; holds its own pool predictor

module particle_pool_integrator_tb;
   import ppi_pkg::*;

   typedef struct packed {
      logic [5:0]         slot;
      logic               pool_full;
      logic               has_particle;
      logic [3:0]         kind_out;
      logic signed [31:0] out_x, out_y, out_z;
      logic [31:0]        opacity;
      logic               is_last;
   } rsp_item_type;

   typedef struct {
      req_code_type       code;
      logic [3:0]         kind;
      logic [23:0]        life;
      logic signed [31:0] p[3];
      logic signed [31:0] v[3];
      logic signed [31:0] a[3];
   } req_item_type;

   // pool predictor plus queue of expected responses
   class pool_scoreboard;
      logic [15:0]        step;
      bit                 live[64];
      logic [3:0]         kind[64];
      logic signed [31:0] life[64];
      logic signed [31:0] pos[64][3];
      logic signed [31:0] vel[64][3];
      logic signed [31:0] acc[64][3];
      logic [31:0]        opac[64];
      rsp_item_type       pending[$];
      int                 mismatches;

      function new();
         step = StepReset;
         mismatches = 0;
         foreach (live[i]) live[i] = 0;
      endfunction

      function void add_expected(rsp_item_type e);
         pending = {pending, e};
      endfunction

      // base + floor(rate*dt/2^16), saturated to 32 signed bits
      function logic signed [31:0] euler_add(logic signed [31:0] base,
                                             logic signed [31:0] rate);
         longint prod, sum;
         prod = longint'(rate) * longint'({16'd0, step});
         sum = longint'(base) + (prod >>> 16);
         if (sum > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (sum < -64'sd2147483648) return 32'sh8000_0000;
         return sum[31:0];
      endfunction

      function logic [31:0] fade(logic signed [31:0] l);
         logic [63:0] m, s, q;
         m = (l < 0) ? 64'(-l) : 64'(l);
         s = (m * m) >> 16;
         if (s >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
         q = (s * s) >> 16;
         if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
         return q[31:0];
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type e;
         int n;
         e = '{default: 0};
         case (r.code)
            REQ_SPAWN: begin
               e.is_last = 1;
               e.pool_full = 1;
               for (int i = 0; i < 64; i++) begin
                  if (!live[i]) begin
                     live[i] = 1; kind[i] = r.kind; life[i] = {8'd0, r.life};
                     for (int k = 0; k < 3; k++) begin
                        pos[i][k] = r.p[k]; vel[i][k] = r.v[k]; acc[i][k] = r.a[k];
                     end
                     opac[i] = OneQ16;
                     e.pool_full = 0; e.slot = 6'(i);
                     break;
                  end
               end
               add_expected(e);
            end
            REQ_TICK: begin
               for (int i = 0; i < 64; i++) begin
                  if (!live[i]) continue;
                  for (int k = 0; k < 3; k++) vel[i][k] = euler_add(vel[i][k], acc[i][k]);
                  for (int k = 0; k < 3; k++) pos[i][k] = euler_add(pos[i][k], vel[i][k]);
                  life[i] = life[i] - $signed({16'd0, step});
                  opac[i] = fade(life[i]);
                  if (life[i] <= 0) live[i] = 0;
               end
            end
            REQ_DUMP: begin
               n = 0;
               for (int i = 0; i < 64; i++) begin
                  if (!live[i]) continue;
                  e = '{default: 0};
                  e.slot = 6'(i); e.has_particle = 1; e.kind_out = kind[i];
                  e.out_x = pos[i][0]; e.out_y = pos[i][1]; e.out_z = pos[i][2];
                  e.opacity = opac[i];
                  add_expected(e);
                  n++;
               end
               if (n == 0) begin
                  e = '{default: 0};
                  add_expected(e);
               end
               pending[$].is_last = 1;
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response slot %0d", got.slot);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %p\n          got %p", e, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_write = 0;
   logic [15:0] csr_time_step = StepReset;
   logic req_valid = 0, rsp_ready = 0;
   logic req_ready, rsp_valid;
   logic [1:0] req_type = REQ_NONE;
   logic [3:0] particle_kind = 0;
   logic [23:0] lifetime = 0;
   logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
   logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
   logic signed [31:0] accel_x = 0, accel_y = 0, accel_z = 0;
   logic [5:0] slot;
   logic pool_full, has_particle, is_last;
   logic [3:0] kind_out;
   logic signed [31:0] out_x, out_y, out_z;
   logic [31:0] opacity;

   particle_pool_integrator uut (.*);

   pool_scoreboard sb = new();
   bit  idle_gaps = 1;      // random idling on both sides while set
   bit  hold_rsp = 0;       // long receiver hold-off request
   int  cycles = 0;

   initial forever #5 clock = ~clock;

   // run limit: every slot spends worst-case cycles, many times over
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end else if (idle_gaps && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_ready <= 0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.slot = slot; got.pool_full = pool_full; got.has_particle = has_particle;
         got.kind_out = kind_out; got.out_x = out_x; got.out_y = out_y;
         got.out_z = out_z; got.opacity = opacity; got.is_last = is_last;
         sb.check_response(got);
      end
   end

   function automatic logic signed [31:0] rnd_word();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_item_type rnd_request(int spawn_weight);
      req_item_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < spawn_weight) r.code = REQ_SPAWN;
      else if (pick < spawn_weight + (100 - spawn_weight) * 2 / 3) r.code = REQ_TICK;
      else if (pick < 98) r.code = REQ_DUMP;
      else r.code = REQ_NONE;
      r.kind = 4'($urandom);
      case ($urandom_range(0, 3))
         0: r.life = 24'($urandom);
         1: r.life = 24'($urandom_range(0, 4000));
         default: r.life = 24'($urandom_range(0, 24'h04_0000));
      endcase
      for (int k = 0; k < 3; k++) begin
         r.p[k] = rnd_word(); r.v[k] = rnd_word(); r.a[k] = rnd_word();
      end
      return r;
   endfunction

   // one item on the request channel, with an optional idle burst first
   task automatic send_request(req_item_type r);
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= r.code; particle_kind <= r.kind; lifetime <= r.life;
      pos_x <= r.p[0]; pos_y <= r.p[1]; pos_z <= r.p[2];
      vel_x <= r.v[0]; vel_y <= r.v[1]; vel_z <= r.v[2];
      accel_x <= r.a[0]; accel_y <= r.a[1]; accel_z <= r.a[2];
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   // stop offering, wait until every expected item has come, then let the block settle
   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_step(logic [15:0] val);
      csr_write <= 1; csr_time_step <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.step = val;
   endtask

   task automatic directed_item(req_code_type c, logic [23:0] l,
                                logic signed [31:0] w);
      req_item_type r;
      r.code = c; r.kind = 4'hF; r.life = l;
      for (int k = 0; k < 3; k++) begin
         r.p[k] = w; r.v[k] = w; r.a[k] = w;
      end
      send_request(r);
   endtask

   initial begin
      req_item_type r;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty dump, extremes, zero lifetime, unused code, zero step
      directed_item(REQ_DUMP, 0, 0);
      directed_item(REQ_SPAWN, 24'hFF_FFFF, 32'sh7FFF_FFFF);
      directed_item(REQ_SPAWN, 24'hFF_FFFF, 32'sh8000_0000);
      directed_item(REQ_SPAWN, 0, 0);
      directed_item(REQ_SPAWN, 24'h00_0400, -32'sd1);
      directed_item(REQ_NONE, 24'h12_3456, 32'sh5555_AAAA);
      directed_item(REQ_DUMP, 0, 0);
      directed_item(REQ_TICK, 0, 0);
      directed_item(REQ_DUMP, 0, 0);
      drain();
      write_step(16'hFFFF);
      directed_item(REQ_TICK, 0, 0);
      directed_item(REQ_DUMP, 0, 0);
      drain();
      write_step(16'h0000);
      directed_item(REQ_SPAWN, 24'h00_0001, 32'sh0001_0000);
      directed_item(REQ_TICK, 0, 0);
      directed_item(REQ_DUMP, 0, 0);
      drain();
      write_step(StepReset);

      // fill the pool past full to exercise the full flag and the long hold-off
      hold_rsp = 1;
      for (int i = 0; i < 68; i++) begin
         r = rnd_request(100);
         r.life = 24'hFF_FFFF;
         send_request(r);
      end
      directed_item(REQ_DUMP, 0, 0);
      drain();
      for (int i = 0; i < 4; i++) directed_item(REQ_TICK, 0, 0);
      drain();

      // random phases with different step settings
      for (int ph = 0; ph < 4; ph++) begin
         write_step(ph == 0 ? 16'h8000 : ph == 3 ? StepReset : 16'($urandom));
         if (ph == 3) idle_gaps = 0;
         for (int i = 0; i < 35; i++) send_request(rnd_request(45));
         directed_item(REQ_DUMP, 0, 0);
         drain();
      end

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
